>>> rtl/core/bclru_pkg.sv
package bclru_pkg;

    localparam int BLOCK_BITS_DEF = 16;
    localparam int ENTRIES_DEF    = 16;

    localparam int OFFSET_W  = 48;
    localparam int VERSION_W = 31;
    localparam int END_W     = 49;
    localparam int SLOT_W    = 4;
    localparam int LEN_W     = 17;
    localparam int STAMP_W   = 64;

    typedef struct packed {
        logic [OFFSET_W-1:0]  byte_offset;
        logic [VERSION_W-1:0] object_version;
        logic [END_W-1:0]     object_end;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic                fetch_needed;
        logic                no_data;
        logic [SLOT_W-1:0]   slot_index;
        logic [OFFSET_W-1:0] block_base;
        logic [LEN_W-1:0]    block_length;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic scan_issue;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

endpackage

>>> rtl/core/block_cache_lru_lookup_unit.sv
// Block cache lookup, fully associative, least-recently-used replacement.
// Request channel: req_valid / req_stall carry one beat per block request
// (byte offset, version, object end). Response channel: rsp_valid /
// rsp_stall carry one beat per request, in order.
// A request beat is captured in IDLE, looked up in LOOKUP and its response is
// registered in COMMIT. A request that hits, finds a free entry or lies at or
// past the object end goes straight from LOOKUP to COMMIT; a miss with every
// entry in use first walks the stamp memory one entry per cycle in SCAN to find
// the oldest, then passes DRAIN. One request is handled at a time: the next
// beat is taken in the commit cycle of the previous one.
// Reset clears all entry valid bits and the stamp counter at once, with no
// sweep; the first request can follow immediately.
// When the receiver stalls, the response beat holds in its register and the
// block finishes the next lookup, then waits in commit until the slot frees.
module block_cache_lru_lookup_unit #(
    parameter int BLOCK_BITS = bclru_pkg::BLOCK_BITS_DEF,
    parameter int ENTRIES    = bclru_pkg::ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bclru_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bclru_pkg::rsp_t rsp
);
    import bclru_pkg::*;

    cmd_t    cmd;
    status_t status;

    bclru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bclru_datapath #(
        .BLOCK_BITS (BLOCK_BITS),
        .ENTRIES    (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> rtl/core/bclru_ctrl.sv
module bclru_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bclru_pkg::status_t status,
    output bclru_pkg::cmd_t    cmd
);
    import bclru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        req_stall      = 1'b1;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = status.need_scan ? ST_SCAN : ST_COMMIT;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last stamp read lands this cycle
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit  = 1'b1;
                    req_stall   = 1'b0;
                    cmd.capture = req_valid;
                    state_next  = req_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/bclru_datapath.sv
module bclru_datapath #(
    parameter int BLOCK_BITS = bclru_pkg::BLOCK_BITS_DEF,
    parameter int ENTRIES    = bclru_pkg::ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bclru_pkg::req_t    req,
    input  bclru_pkg::cmd_t    cmd,
    input  logic               rsp_stall,
    output bclru_pkg::status_t status,
    output logic               rsp_valid,
    output bclru_pkg::rsp_t    rsp
);
    import bclru_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int TAG_W = OFFSET_W - BLOCK_BITS;
    localparam logic [END_W-1:0] BLK_SIZE = END_W'(64'd1 << BLOCK_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // request
    logic [OFFSET_W-1:0]  base_reg;
    logic [VERSION_W-1:0] ver_reg;
    logic [END_W-1:0]     end_reg;

    // table: tags and versions as compare lanes, stamps and lengths in memories
    logic [ENTRIES-1:0]   valid_reg;
    logic [TAG_W-1:0]     tag_reg [ENTRIES];
    logic [VERSION_W-1:0] ver_arr_reg [ENTRIES];
    logic [STAMP_W-1:0]   stamp_mem [ENTRIES];
    logic [LEN_W-1:0]     length_mem [ENTRIES];
    logic [STAMP_W-1:0]   stamp_cnt_reg;

    // lookup results
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             inv_reg;
    logic [IDX_W-1:0] inv_idx_reg;
    logic             nodata_reg;
    logic [LEN_W-1:0] len_fill_reg;
    logic [LEN_W-1:0] len_rd_reg;

    // LRU scan
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [IDX_W-1:0]   victim_reg;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             hit_c;
    logic [IDX_W-1:0] hit_idx_c;
    logic             inv_c;
    logic [IDX_W-1:0] inv_idx_c;
    logic             nodata_c;
    logic [END_W-1:0] diff_c;
    logic [END_W-1:0] clamp_c;
    logic [TAG_W-1:0] tag_c;
    logic [IDX_W-1:0] slot_sel;
    logic             do_fill;
    logic             do_touch;

    assign tag_c = base_reg[OFFSET_W-1:BLOCK_BITS];

    // first matching entry and first free entry
    always_comb
    begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        inv_c     = 1'b0;
        inv_idx_c = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!hit_c && valid_reg[i] && tag_reg[i] == tag_c && ver_arr_reg[i] == ver_reg)
            begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!inv_c && !valid_reg[i])
            begin
                inv_c     = 1'b1;
                inv_idx_c = IDX_W'(i);
            end
        end
    end

    assign nodata_c = end_reg <= END_W'(base_reg);
    assign diff_c   = end_reg - END_W'(base_reg);
    assign clamp_c  = (diff_c > BLK_SIZE) ? BLK_SIZE : diff_c;

    assign slot_sel = hit_reg ? hit_idx_reg : (inv_reg ? inv_idx_reg : victim_reg);
    assign do_fill  = !hit_reg && !nodata_reg;
    assign do_touch = hit_reg || do_fill;

    assign status.need_scan = !hit_c && !inv_c && !nodata_c;
    assign status.scan_last = scan_cnt_reg == LAST_IDX;
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            base_reg <= {req.byte_offset[OFFSET_W-1:BLOCK_BITS], BLOCK_BITS'(0)};
            ver_reg  <= req.object_version;
            end_reg  <= req.object_end;
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            inv_reg      <= inv_c;
            inv_idx_reg  <= inv_idx_c;
            nodata_reg   <= nodata_c;
            len_fill_reg <= LEN_W'(clamp_c);
            len_rd_reg   <= length_mem[hit_idx_c];
            scan_cnt_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (cmd.scan_issue)
        begin
            stamp_rd_reg <= stamp_mem[scan_cnt_reg];
            rd_idx_reg   <= scan_cnt_reg;
        end
        // best starts at the counter: only stamps below it qualify
        if (cmd.lookup)
        begin
            best_reg   <= stamp_cnt_reg;
            victim_reg <= '0;
        end
        else if (rd_valid_reg && stamp_rd_reg < best_reg)
        begin
            best_reg   <= stamp_rd_reg;
            victim_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            if (do_touch)
            begin
                stamp_mem[slot_sel] <= stamp_cnt_reg;
            end
            if (do_fill)
            begin
                length_mem[slot_sel]  <= len_fill_reg;
                tag_reg[slot_sel]     <= tag_c;
                ver_arr_reg[slot_sel] <= ver_reg;
            end
            rsp_reg.hit          <= hit_reg;
            rsp_reg.fetch_needed <= do_fill;
            rsp_reg.no_data      <= !do_touch;
            rsp_reg.slot_index   <= do_touch ? SLOT_W'(slot_sel) : '0;
            rsp_reg.block_base   <= base_reg;
            rsp_reg.block_length <= hit_reg ? len_rd_reg : (do_fill ? len_fill_reg : '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            stamp_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
                if (do_touch)
                begin
                    stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                end
                if (do_fill)
                begin
                    valid_reg[slot_sel] <= 1'b1;
                end
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule
